/* rtl/scdd_pkg.sv */
// Shared types, character codes and lookup functions of the serial command digit display.
package scdd_pkg;

    localparam int NUM_DIGITS_DEF = 8;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [3:0] BLANK_CODE = 4'hA;

    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_A    = 8'h41;
    localparam logic [7:0] CH_C    = 8'h43;
    localparam logic [7:0] CH_K    = 8'h4B;
    localparam logic [7:0] CH_N    = 8'h4E;
    localparam logic [7:0] CH_O    = 8'h4F;
    localparam logic [7:0] CH_R    = 8'h52;
    localparam logic [7:0] CH_T    = 8'h54;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;

    localparam logic [7:0] SEG_BLANK = 8'hFF;

    typedef enum logic [2:0] {
        PS_IDLE,
        PS_A,
        PS_T,
        PS_C,
        PS_N,
        PS_X,
        PS_CR
    } parse_state_t;

    typedef enum logic [1:0] {
        JOB_DISP,
        JOB_OK,
        JOB_ERR
    } job_kind_t;

    typedef struct packed {
        job_kind_t  kind;
        logic [7:0] seg;
        logic [7:0] en;
    } scdd_job_t;

    function automatic logic [7:0] seg_lookup(input logic [3:0] code);
        logic [7:0] seg;
        case (code)
            4'd0:    seg = 8'hC0;
            4'd1:    seg = 8'hF9;
            4'd2:    seg = 8'hA4;
            4'd3:    seg = 8'hB0;
            4'd4:    seg = 8'h99;
            4'd5:    seg = 8'h92;
            4'd6:    seg = 8'h82;
            4'd7:    seg = 8'hF8;
            4'd8:    seg = 8'h80;
            4'd9:    seg = 8'h90;
            default: seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

    function automatic logic [7:0] reply_char(input job_kind_t kind, input logic [1:0] beat);
        logic [7:0] ch;
        ch = 8'h00;
        unique case (kind)
            JOB_OK: begin
                case (beat)
                    2'd0:    ch = CH_O;
                    2'd1:    ch = CH_K;
                    2'd2:    ch = CH_CR;
                    default: ch = CH_LF;
                endcase
            end
            JOB_ERR: begin
                case (beat)
                    2'd0:    ch = CH_R;
                    2'd1:    ch = CH_CR;
                    default: ch = CH_LF;
                endcase
            end
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic beat_is_last(input job_kind_t kind, input logic [1:0] beat);
        logic lst;
        unique case (kind)
            JOB_OK:  lst = (beat == 2'd3);
            JOB_ERR: lst = (beat == 2'd2);
            default: lst = 1'b1;
        endcase
        return lst;
    endfunction

endpackage

/* rtl/scdd_front.sv */
// Front part: command parser, digit store and scan position; emits one job per result burst.
module scdd_front #(
    parameter int NUM_DIGITS = scdd_pkg::NUM_DIGITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  logic                in_kind,
    input  logic [7:0]          in_byte,
    input  logic                q_full,
    output logic                in_ready,
    output logic                push,
    output scdd_pkg::scdd_job_t push_job
);

    localparam int IDX_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam int CNT_W = $clog2(NUM_DIGITS + 1);

    scdd_pkg::parse_state_t state_reg, state_next;
    logic [3:0]       store_reg [NUM_DIGITS];
    logic [CNT_W-1:0] count_reg;
    logic [IDX_W-1:0] scan_reg;

    logic accept;
    logic is_digit;
    logic do_clear;
    logic do_shift;
    logic do_error;
    logic do_ok;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign is_digit = (in_byte >= scdd_pkg::CH_ZERO) && (in_byte <= scdd_pkg::CH_NINE);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            scdd_pkg::PS_IDLE: begin
                if (in_byte == scdd_pkg::CH_A) begin
                    state_next = scdd_pkg::PS_A;
                end else if (in_byte == scdd_pkg::CH_C) begin
                    state_next = scdd_pkg::PS_C;
                end else if (in_byte == scdd_pkg::CH_N) begin
                    state_next = scdd_pkg::PS_N;
                end else begin
                    state_next = scdd_pkg::PS_IDLE;
                end
            end
            scdd_pkg::PS_A: begin
                state_next = (in_byte == scdd_pkg::CH_T) ? scdd_pkg::PS_T : scdd_pkg::PS_IDLE;
            end
            scdd_pkg::PS_T, scdd_pkg::PS_C: begin
                state_next = (in_byte == scdd_pkg::CH_CR) ? scdd_pkg::PS_CR : scdd_pkg::PS_IDLE;
            end
            scdd_pkg::PS_N: begin
                state_next = is_digit ? scdd_pkg::PS_X : scdd_pkg::PS_IDLE;
            end
            scdd_pkg::PS_X: begin
                if (is_digit) begin
                    state_next = scdd_pkg::PS_X;
                end else if (in_byte == scdd_pkg::CH_CR) begin
                    state_next = scdd_pkg::PS_CR;
                end else begin
                    state_next = scdd_pkg::PS_IDLE;
                end
            end
            scdd_pkg::PS_CR: begin
                state_next = scdd_pkg::PS_IDLE;
            end
            default: state_next = scdd_pkg::PS_IDLE;
        endcase
    end

    always_comb begin
        do_clear = 1'b0;
        do_shift = 1'b0;
        do_error = 1'b0;
        do_ok    = 1'b0;
        unique case (state_reg)
            scdd_pkg::PS_IDLE: begin
                do_clear = (in_byte == scdd_pkg::CH_C) || (in_byte == scdd_pkg::CH_N);
                do_error = !do_clear && (in_byte != scdd_pkg::CH_A);
            end
            scdd_pkg::PS_A: do_error = (in_byte != scdd_pkg::CH_T);
            scdd_pkg::PS_T, scdd_pkg::PS_C: do_error = (in_byte != scdd_pkg::CH_CR);
            scdd_pkg::PS_N: begin
                do_shift = is_digit;
                do_error = !is_digit;
            end
            scdd_pkg::PS_X: begin
                do_shift = is_digit;
                do_error = !is_digit && (in_byte != scdd_pkg::CH_CR);
            end
            scdd_pkg::PS_CR: begin
                do_ok    = (in_byte == scdd_pkg::CH_LF);
                do_error = (in_byte != scdd_pkg::CH_LF);
            end
            default: do_error = 1'b1;
        endcase
    end

    always_comb begin
        push_job.seg  = scdd_pkg::SEG_BLANK;
        push_job.en   = 8'h00;
        push_job.kind = scdd_pkg::JOB_DISP;
        push          = 1'b0;
        if (in_kind) begin
            push_job.seg = scdd_pkg::seg_lookup(store_reg[scan_reg]);
            if (32'(scan_reg) < 32'd8) begin
                push_job.en = 8'd1 << scan_reg;
            end
            push = accept;
        end else if (do_ok) begin
            push_job.kind = scdd_pkg::JOB_OK;
            push          = accept;
        end else if (do_error) begin
            push_job.kind = scdd_pkg::JOB_ERR;
            push          = accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= scdd_pkg::PS_IDLE;
            count_reg <= '0;
            scan_reg  <= '0;
            for (int i = 0; i < NUM_DIGITS; i++) begin
                store_reg[i] <= scdd_pkg::BLANK_CODE;
            end
        end else if (accept) begin
            if (in_kind) begin
                if (scan_reg == IDX_W'(NUM_DIGITS - 1)) begin
                    scan_reg <= '0;
                end else begin
                    scan_reg <= scan_reg + 1'b1;
                end
            end else if (do_error) begin
                state_reg <= scdd_pkg::PS_IDLE;
                count_reg <= '0;
                scan_reg  <= '0;
                for (int i = 0; i < NUM_DIGITS; i++) begin
                    store_reg[i] <= scdd_pkg::BLANK_CODE;
                end
            end else begin
                state_reg <= state_next;
                if (do_clear) begin
                    count_reg <= '0;
                    for (int i = 0; i < NUM_DIGITS; i++) begin
                        store_reg[i] <= scdd_pkg::BLANK_CODE;
                    end
                end else if (do_shift && (count_reg < CNT_W'(NUM_DIGITS))) begin
                    count_reg <= count_reg + 1'b1;
                    for (int i = NUM_DIGITS - 1; i > 0; i--) begin
                        store_reg[i] <= store_reg[i-1];
                    end
                    store_reg[0] <= 4'(in_byte - scdd_pkg::CH_ZERO);
                end
            end
        end
    end

endmodule

/* rtl/scdd_queue.sv */
// Short job queue between the parser and the result sequencer.
module scdd_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  scdd_pkg::scdd_job_t push_job,
    input  logic                pop,
    output logic                full,
    output logic                q_valid,
    output scdd_pkg::scdd_job_t q_job
);

    localparam int PTR_W = $clog2(scdd_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(scdd_pkg::QUEUE_DEPTH + 1);

    scdd_pkg::scdd_job_t mem [scdd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full    = (count_reg == CNT_W'(scdd_pkg::QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_job   = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/scdd_back.sv */
// Back part: expands each job into its result items and holds them in the output register.
module scdd_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  scdd_pkg::scdd_job_t q_job,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [23:0]         m_tdata,
    output logic                m_tuser,
    output logic                m_tlast
);

    scdd_pkg::scdd_job_t job_reg;
    logic        active_reg;
    logic [1:0]  beat_reg;
    logic        valid_reg;
    logic [23:0] data_reg;
    logic        user_reg;
    logic        last_reg;

    logic out_free;
    logic fire;
    logic beat_last;
    logic done;

    assign out_free  = !valid_reg || m_tready;
    assign fire      = active_reg && out_free;
    assign beat_last = scdd_pkg::beat_is_last(job_reg.kind, beat_reg);
    assign done      = fire && beat_last;
    assign pop       = q_valid && (!active_reg || done);

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            beat_reg   <= '0;
        end else if (pop) begin
            active_reg <= 1'b1;
            beat_reg   <= '0;
        end else if (done) begin
            active_reg <= 1'b0;
        end else if (fire) begin
            beat_reg <= beat_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            job_reg <= q_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (fire) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            last_reg <= beat_last;
            if (job_reg.kind == scdd_pkg::JOB_DISP) begin
                user_reg <= 1'b0;
                data_reg <= {job_reg.en, job_reg.seg, 8'h00};
            end else begin
                user_reg <= 1'b1;
                data_reg <= {8'h00, scdd_pkg::SEG_BLANK,
                             scdd_pkg::reply_char(job_reg.kind, beat_reg)};
            end
        end
    end

endmodule

/* rtl/serial_command_digit_display.sv */
// Top level of the serial command parser with seven-segment digit display driver.
// Each input item is a received byte (s_tuser low) or a refresh tick (s_tuser high). The parser
// takes one item per clock cycle while its four-entry job queue has room; a tick yields one
// display result, a byte that completes a command yields four reply results, an invalid byte
// yields three and any other byte yields none. The result sequencer emits one result per cycle
// while the output is not stalled, so the output side, which emits up to four results per input
// item, sets the sustained rate.
module serial_command_digit_display #(
    parameter int NUM_DIGITS = scdd_pkg::NUM_DIGITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // reply_byte, segments, digit_enable
    output logic        m_tuser,   // is_reply
    output logic        m_tlast    // last
);

    logic                q_full;
    logic                push;
    scdd_pkg::scdd_job_t push_job;
    logic                pop;
    logic                q_valid;
    scdd_pkg::scdd_job_t q_job;

    scdd_front #(
        .NUM_DIGITS(NUM_DIGITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_kind  (s_tuser),
        .in_byte  (s_tdata),
        .q_full   (q_full),
        .in_ready (s_tready),
        .push     (push),
        .push_job (push_job)
    );

    scdd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .full     (q_full),
        .q_valid  (q_valid),
        .q_job    (q_job)
    );

    scdd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_job    (q_job),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

/* bench/serial_command_digit_display_test.sv */
// Self-checking testbench for the serial command parser and seven-segment display driver.
module serial_command_digit_display_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIGITS = scdd_pkg::NUM_DIGITS_DEF;
    localparam int RANDOM_ITEMS = 310;
    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD = 400;

    typedef struct packed {
        logic       is_reply;
        logic [7:0] reply_byte;
        logic [7:0] segments;
        logic [7:0] digit_enable;
        logic       last;
    } disp_result_t;

    typedef struct packed {
        logic         kind;
        logic [7:0]   rx;
        logic         typed;
        disp_result_t first;
    } plan_row_t;

    localparam disp_result_t NO_CHECK = '0;
    localparam disp_result_t BLANK_AT_0 =
        '{1'b0, 8'h00, scdd_pkg::SEG_BLANK, 8'h01, 1'b1};
    localparam disp_result_t ERR_FIRST =
        '{1'b1, scdd_pkg::CH_R, scdd_pkg::SEG_BLANK, 8'h00, 1'b0};
    localparam disp_result_t OK_FIRST =
        '{1'b1, scdd_pkg::CH_O, scdd_pkg::SEG_BLANK, 8'h00, 1'b0};

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    serial_command_digit_display dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    plan_row_t directed_plan [25] = '{
        '{1'b1, 8'h00, 1'b1, BLANK_AT_0},
        '{1'b0, scdd_pkg::CH_A, 1'b0, NO_CHECK},
        '{1'b0, scdd_pkg::CH_T, 1'b0, NO_CHECK},
        '{1'b0, scdd_pkg::CH_CR, 1'b0, NO_CHECK},
        '{1'b0, scdd_pkg::CH_LF, 1'b1, OK_FIRST},
        '{1'b0, scdd_pkg::CH_C, 1'b0, NO_CHECK},
        '{1'b0, scdd_pkg::CH_CR, 1'b0, NO_CHECK},
        '{1'b0, scdd_pkg::CH_LF, 1'b0, NO_CHECK},
        '{1'b0, 8'h00, 1'b1, ERR_FIRST},
        '{1'b1, 8'hFF, 1'b1, BLANK_AT_0},
        '{1'b0, scdd_pkg::CH_N, 1'b0, NO_CHECK},
        '{1'b0, scdd_pkg::CH_ZERO, 1'b0, NO_CHECK},
        '{1'b0, scdd_pkg::CH_NINE, 1'b0, NO_CHECK},
        '{1'b0, scdd_pkg::CH_ZERO + 8'd1, 1'b0, NO_CHECK},
        '{1'b0, scdd_pkg::CH_ZERO + 8'd2, 1'b0, NO_CHECK},
        '{1'b0, scdd_pkg::CH_ZERO + 8'd3, 1'b0, NO_CHECK},
        '{1'b0, scdd_pkg::CH_ZERO + 8'd4, 1'b0, NO_CHECK},
        '{1'b0, scdd_pkg::CH_ZERO + 8'd5, 1'b0, NO_CHECK},
        '{1'b0, scdd_pkg::CH_ZERO + 8'd6, 1'b0, NO_CHECK},
        '{1'b0, scdd_pkg::CH_ZERO + 8'd7, 1'b0, NO_CHECK},
        '{1'b0, scdd_pkg::CH_CR, 1'b0, NO_CHECK},
        '{1'b0, scdd_pkg::CH_LF, 1'b0, NO_CHECK},
        '{1'b1, 8'h5A, 1'b0, NO_CHECK},
        '{1'b1, 8'hA5, 1'b0, NO_CHECK},
        '{1'b0, 8'hFF, 1'b1, ERR_FIRST}
    };

    scdd_pkg::parse_state_t parser_m;
    logic [3:0]     digits_m [DIGITS];
    int unsigned    held_m;
    int unsigned    scan_m;
    logic [7:0]     seg_rom [11];

    disp_result_t   step_out [$];
    disp_result_t   results_due [$];
    logic [8:0]     stim_q [$];
    disp_result_t   got;
    disp_result_t   want;
    int             errors = 0;
    int             offered = 0;
    int             delivered = 0;
    int             idle_cycles = 0;
    logic           calm = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    task automatic clear_model();
        parser_m = scdd_pkg::PS_IDLE;
        foreach (digits_m[i]) digits_m[i] = scdd_pkg::BLANK_CODE;
        held_m = 0;
        scan_m = 0;
    endtask

    function automatic disp_result_t reply_beat(input logic [7:0] ch, input logic lst);
        return '{1'b1, ch, scdd_pkg::SEG_BLANK, 8'h00, lst};
    endfunction

    task automatic advance_display_model(input logic k, input logic [7:0] b);
        logic is_num;
        step_out.delete();
        if (k) begin
            step_out.push_back('{1'b0, 8'h00, seg_rom[digits_m[scan_m]],
                                 8'(1 << scan_m), 1'b1});
            scan_m = (scan_m + 1) % DIGITS;
        end else begin
            is_num = (b >= scdd_pkg::CH_ZERO) && (b <= scdd_pkg::CH_NINE);
            if (parser_m == scdd_pkg::PS_IDLE && b == scdd_pkg::CH_A) begin
                parser_m = scdd_pkg::PS_A;
            end else if (parser_m == scdd_pkg::PS_IDLE
                         && (b == scdd_pkg::CH_C || b == scdd_pkg::CH_N)) begin
                foreach (digits_m[i]) digits_m[i] = scdd_pkg::BLANK_CODE;
                held_m = 0;
                parser_m = (b == scdd_pkg::CH_C) ? scdd_pkg::PS_C : scdd_pkg::PS_N;
            end else if (parser_m == scdd_pkg::PS_A && b == scdd_pkg::CH_T) begin
                parser_m = scdd_pkg::PS_T;
            end else if (b == scdd_pkg::CH_CR && (parser_m == scdd_pkg::PS_T
                                                  || parser_m == scdd_pkg::PS_C
                                                  || parser_m == scdd_pkg::PS_X)) begin
                parser_m = scdd_pkg::PS_CR;
            end else if (is_num && (parser_m == scdd_pkg::PS_N
                                    || parser_m == scdd_pkg::PS_X)) begin
                if (held_m < DIGITS) begin
                    for (int i = DIGITS - 1; i > 0; i--) digits_m[i] = digits_m[i - 1];
                    digits_m[0] = 4'(b - scdd_pkg::CH_ZERO);
                    held_m++;
                end
                parser_m = scdd_pkg::PS_X;
            end else if (parser_m == scdd_pkg::PS_CR && b == scdd_pkg::CH_LF) begin
                parser_m = scdd_pkg::PS_IDLE;
                step_out.push_back(reply_beat(scdd_pkg::CH_O, 1'b0));
                step_out.push_back(reply_beat(scdd_pkg::CH_K, 1'b0));
                step_out.push_back(reply_beat(scdd_pkg::CH_CR, 1'b0));
                step_out.push_back(reply_beat(scdd_pkg::CH_LF, 1'b1));
            end else begin
                clear_model();
                step_out.push_back(reply_beat(scdd_pkg::CH_R, 1'b0));
                step_out.push_back(reply_beat(scdd_pkg::CH_CR, 1'b0));
                step_out.push_back(reply_beat(scdd_pkg::CH_LF, 1'b1));
            end
        end
    endtask

    task automatic offer_item(input logic k, input logic [7:0] b, input logic typed,
                              input disp_result_t first);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        advance_display_model(k, b);
        if (typed) step_out[0] = first;
        foreach (step_out[i]) results_due.push_back(step_out[i]);
        offered++;
        if (offered % 32 == 0) calm = ($urandom_range(0, 3) == 0);
        @(negedge aclk);
    endtask

    task automatic push_byte(input logic [7:0] b);
        stim_q.push_back({1'b0, b});
        if ($urandom_range(0, 3) == 0) stim_q.push_back({1'b1, 8'($urandom)});
    endtask

    task automatic plan_random_burst();
        logic [7:0] cmd [$];
        int sel;
        int n;
        int cut;
        sel = $urandom_range(0, 11);
        if (sel >= 10) begin
            repeat ($urandom_range(1, 8)) stim_q.push_back({1'b1, 8'($urandom)});
        end else if (sel == 9) begin
            push_byte(8'($urandom));
        end else begin
            case (sel % 3)
                0: cmd = {scdd_pkg::CH_A, scdd_pkg::CH_T};
                1: cmd = {scdd_pkg::CH_C};
                default: begin
                    cmd = {scdd_pkg::CH_N};
                    n = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 12)
                                                    : $urandom_range(0, 8);
                    repeat (n) cmd.push_back(scdd_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
                end
            endcase
            cmd.push_back(scdd_pkg::CH_CR);
            cmd.push_back(scdd_pkg::CH_LF);
            if ($urandom_range(0, 7) == 0) begin
                cut = $urandom_range(1, cmd.size() - 1);
                cmd = cmd[0:cut-1];
                cmd.push_back(8'($urandom));
            end
            foreach (cmd[i]) push_byte(cmd[i]);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tuser, m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tlast};
            delivered++;
            if (results_due.size() == 0) begin
                $display("%0t: unexpected result, actual %p", $time, got);
                errors++;
            end else begin
                want = results_due.pop_front();
                if (got !== want) begin
                    $display("%0t: result mismatch, expected %p, actual %p", $time, want, got);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        int stall;
        logic held_off;
        logic rx_calm;
        held_off = 1'b0;
        rx_calm = 1'b0;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            if (!held_off && delivered >= 80) begin
                held_off = 1'b1;
                stall = LONG_HOLD;
            end else begin
                stall = rx_calm ? 0 : $urandom_range(0, 6);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            if (delivered % 32 == 0) rx_calm = ($urandom_range(0, 3) == 0);
            @(negedge aclk);
        end
    end

    initial begin
        logic [8:0] item;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        s_tuser  = 1'b0;
        seg_rom  = '{8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92,
                     8'h82, 8'hF8, 8'h80, 8'h90, scdd_pkg::SEG_BLANK};
        clear_model();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_plan[i])
            offer_item(directed_plan[i].kind, directed_plan[i].rx,
                       directed_plan[i].typed, directed_plan[i].first);

        while (offered < RANDOM_ITEMS + 25) begin
            if (stim_q.size() == 0) plan_random_burst();
            item = stim_q.pop_front();
            offer_item(item[8], item[7:0], 1'b0, NO_CHECK);
        end
        s_tvalid <= 1'b0;

        while (results_due.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0 && results_due.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
